FILE: sv/btmg_pkg.sv
// ----------------------------------------------------------------------------
// btmg_pkg
// Shared widths and constants for the bloom, tone map and gamma pipeline.
// ----------------------------------------------------------------------------
package btmg_pkg;

    localparam int CHAN_W     = 24;  // one HDR or glow channel
    localparam int STR_W      = 12;  // bloom strength, Q4.8
    localparam int PIX_W      = 8;   // display code
    localparam int NUM_LANES  = 3;
    localparam int LANE_LAT   = 36;  // register stages through one lane

    localparam logic [STR_W-1:0] STRENGTH_RESET = 12'd640;

    // Register index of the glow gain (byte address / 4)
    localparam logic REG_STRENGTH = 1'b0;

endpackage

FILE: sv/bloom_tone_map_gamma.sv
// ----------------------------------------------------------------------------
// bloom_tone_map_gamma
// Bloom add, Reinhard tone map and gamma 2 for three channels per pixel.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  hdr r,g,b then glow r,g,b (24b each)
//   m_*      out        m_tvalid/m_tready  out r,g,b (8b each)
//   APB      in/out     psel/penable       glow gain at address 0
//
// One item per clock while the skid register is empty; each item passes 36
// lane stages, 16 of them divide and 16 square root, then the output register.
// Synchronous active-low reset clears valid flags and sets strength to 2.5.
// The whole lane pipeline halts only when the skid register is full.
// ----------------------------------------------------------------------------
module bloom_tone_map_gamma #(
    parameter int HDR_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // hdr_red, hdr_green, hdr_blue, glow_red, glow_green, glow_blue
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,  // out_red, out_green, out_blue
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = btmg_pkg::CHAN_W;
    localparam int NL = btmg_pkg::NUM_LANES;

    // Configuration register
    logic [btmg_pkg::STR_W-1:0] r_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= btmg_pkg::STRENGTH_RESET;
        end else if (psel && penable && pwrite && paddr[2] == btmg_pkg::REG_STRENGTH) begin
            r_strength <= pwdata[btmg_pkg::STR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == btmg_pkg::REG_STRENGTH) ? 32'(r_strength) : '0;

    // Advance every stage together while the skid register is empty
    logic w_en;
    logic [btmg_pkg::LANE_LAT-1:0] r_vld;

    assign s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[btmg_pkg::LANE_LAT-2:0], s_tvalid};
        end
    end

    // Lanes
    logic [NL*btmg_pkg::PIX_W-1:0] w_pix;

    for (genvar l = 0; l < NL; l++) begin : g_lane
        btmg_lane #(.HDR_FRAC_BITS(HDR_FRAC_BITS)) u_lane (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_strength (r_strength),
            .i_hdr      (s_tdata[l*CW +: CW]),
            .i_glow     (s_tdata[(l+NL)*CW +: CW]),
            .o_pix      (w_pix[l*btmg_pkg::PIX_W +: btmg_pkg::PIX_W])
        );
    end

    // Merge and output
    btmg_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_en & r_vld[btmg_pkg::LANE_LAT-1]),
        .i_data       (w_pix),
        .o_ready      (w_en),
        .o_valid      (m_tvalid),
        .i_take_ready (m_tready),
        .o_data       (m_tdata)
    );

endmodule

FILE: sv/btmg_lane.sv
// ----------------------------------------------------------------------------
// btmg_lane
// One colour channel: bloom add, Reinhard divide, square root and scaling,
// fully pipelined with one quotient or root bit resolved per stage.
// ----------------------------------------------------------------------------
module btmg_lane #(
    parameter int HDR_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [btmg_pkg::STR_W-1:0]    i_strength,
    input  logic [btmg_pkg::CHAN_W-1:0]   i_hdr,
    input  logic [btmg_pkg::CHAN_W-1:0]   i_glow,
    output logic [btmg_pkg::PIX_W-1:0]    o_pix
);

    localparam int PROD_W = btmg_pkg::CHAN_W + btmg_pkg::STR_W;
    localparam int REM_W  = btmg_pkg::CHAN_W + 2;
    localparam int QW     = 16;
    localparam int SREM_W = 19;
    localparam logic [REM_W-1:0] ONE_X = REM_W'(1) << HDR_FRAC_BITS;

    // Stage 1: bloom product
    logic [PROD_W-1:0]           r_prod;
    logic [btmg_pkg::CHAN_W-1:0] r_hdr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_strength) * PROD_W'(i_glow);
            r_hdr  <= i_hdr;
        end
    end

    // Stage 2: saturating add, form divisor 1 + x
    logic [PROD_W-8:0] w_sum;
    logic [REM_W-1:0]  w_x;
    assign w_sum = (PROD_W-7)'(r_hdr) + (PROD_W-7)'(r_prod[PROD_W-1:8]);
    assign w_x   = (w_sum > (PROD_W-7)'({btmg_pkg::CHAN_W{1'b1}}))
                   ? REM_W'({btmg_pkg::CHAN_W{1'b1}}) : REM_W'(w_sum);

    logic [REM_W-1:0] r_rem [0:QW];
    logic [REM_W-1:0] r_den [0:QW];
    logic [QW-1:0]    r_q   [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_x;
            r_den[0] <= w_x + ONE_X;
            r_q[0]   <= '0;
        end
    end

    // Divide stages: one quotient bit each, remainder stays below divisor
    for (genvar k = 1; k <= QW; k++) begin : g_div
        logic [REM_W-1:0] w_r2;
        assign w_r2 = {r_rem[k-1][REM_W-2:0], 1'b0};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= r_den[k-1];
                if (w_r2 >= r_den[k-1]) begin
                    r_rem[k] <= w_r2 - r_den[k-1];
                    r_q[k]   <= {r_q[k-1][QW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_r2;
                    r_q[k]   <= {r_q[k-1][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Square root stages over y * 2^16, two radicand bits per stage
    logic [QW-1:0]     r_y    [1:QW];
    logic [SREM_W-1:0] r_srem [1:QW];
    logic [QW-1:0]     r_root [1:QW];

    for (genvar j = 1; j <= QW; j++) begin : g_sqrt
        logic [QW-1:0]     w_yp;
        logic [SREM_W-1:0] w_sp;
        logic [QW-1:0]     w_rp;
        logic [1:0]        w_pair;
        logic [SREM_W-1:0] w_rin;
        logic [SREM_W-1:0] w_t;
        // Take the quotient into the first stage, else the previous stage
        if (j == 1) begin : g_first
            assign w_yp = r_q[QW];
            assign w_sp = '0;
            assign w_rp = '0;
        end else begin : g_next
            assign w_yp = r_y[j-1];
            assign w_sp = r_srem[j-1];
            assign w_rp = r_root[j-1];
        end
        if (j <= QW/2) begin : g_hi
            assign w_pair = w_yp[QW-2*j+1 -: 2];
        end else begin : g_lo
            assign w_pair = 2'b00;
        end
        assign w_rin = {w_sp[SREM_W-3:0], w_pair};
        assign w_t   = {1'b0, w_rp, 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[j] <= w_yp;
                if (w_rin >= w_t) begin
                    r_srem[j] <= w_rin - w_t;
                    r_root[j] <= {w_rp[QW-2:0], 1'b1};
                end else begin
                    r_srem[j] <= w_rin;
                    r_root[j] <= {w_rp[QW-2:0], 1'b0};
                end
            end
        end
    end

    // Scale: s * 25599, then / 2^16 and / 100 by reciprocal 5243 / 2^19
    logic [30:0] r_scaled;
    logic [14:0] w_q1;
    logic [27:0] w_m;
    logic [8:0]  w_o;
    logic [btmg_pkg::PIX_W-1:0] r_pix;

    assign w_q1 = r_scaled[30:16];
    assign w_m  = 28'(w_q1) * 28'd5243;
    assign w_o  = w_m[27:19];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled <= 31'(r_root[QW]) * 31'd25599;
            r_pix    <= (w_o > 9'd255) ? 8'd255 : w_o[7:0];
        end
    end

    assign o_pix = r_pix;

endmodule

FILE: sv/btmg_out.sv
// ----------------------------------------------------------------------------
// btmg_out
// Merge the three lane results into one item and hold it in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
module btmg_out (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_push,
    input  logic [btmg_pkg::NUM_LANES*btmg_pkg::PIX_W-1:0] i_data,
    output logic                                        o_ready,
    output logic                                        o_valid,
    input  logic                                        i_take_ready,
    output logic [btmg_pkg::NUM_LANES*btmg_pkg::PIX_W-1:0] o_data
);

    localparam int DW = btmg_pkg::NUM_LANES * btmg_pkg::PIX_W;

    logic          r_ov, r_sv;
    logic [DW-1:0] r_od, r_sd;
    logic          w_take;

    assign w_take = r_ov & i_take_ready;

    // Hold an item in the skid register while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_sv <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_od <= r_sd;
            end
        end else if (i_push) begin
            if (!r_ov || w_take) begin
                r_od <= i_data;
            end else begin
                r_sd <= i_data;
            end
        end
    end

    assign o_ready = ~r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule
